// File: sv/i2c_write_waveform_gen_assert.svh
// Assertion macros for the I2C write waveform generator.
// Used by the top level only; no other file depends on this header.
`ifndef I2C_WRITE_WAVEFORM_GEN_ASSERT_SVH
`define I2C_WRITE_WAVEFORM_GEN_ASSERT_SVH
`ifndef SYNTH
// Implication or plain property, checked on the rising edge outside reset.
`define IWG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iwg assertion failed");
// Condition that must never be seen outside reset.
`define IWG_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("iwg forbidden condition seen");
`else
`define IWG_ASSERT(lbl, clk, rst_n, prop)
`define IWG_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: sv/iwg_pkg.sv
// Shared types and constants of the I2C write waveform generator.
// No dependencies; imported by the front, queue, back and top level.
`timescale 1ns / 1ps
`default_nettype none

package iwg_pkg;

    // Samples in the frame prefix: START pair plus nine SCL pulses.
    localparam int unsigned PRE_SAMPLES = 20;
    localparam int unsigned DATA_BITS   = 8;
    localparam int unsigned CNT_W       = 5;

    // One byte command as passed from the front to the back.
    // Data is already in sending order: bit 7 goes out first.
    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic                 open_frame;
        logic                 last_byte;
    } t_cmd;

    // Status of the back sequencer, seen by the top level.
    typedef struct packed {
        logic       busy;
        logic [1:0] phase;
    } t_back_status;

endpackage

`default_nettype wire

// File: sv/i2c_write_waveform_gen.sv
// I2C write waveform generator: byte beats in, (SCL, SDA) sample beats out.
// Path: a byte passes through the queue and the sequencer state into the output sample register.
// Throughput: one sample per cycle while the output is not stalled; 27 per byte, plus 20 for a frame-opening byte
// and 4 for a frame-closing byte, set by the single back sequencer.
// Reset: synchronous active low; clears the queue, frame state, order register and sequencer state.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_write_waveform_gen_assert.svh"

module i2c_write_waveform_gen
    import iwg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_scl,
    output logic            o_sda,
    output logic            o_last_sample
);

    logic         q_full, q_push, q_pop, q_valid;
    t_cmd         q_in_cmd, q_out_cmd;
    t_back_status back_status;

    // Front end.
    iwg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_in_stall    (o_in_stall),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in_cmd)
    );

    // Command queue.
    iwg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // Back sequencer.
    iwg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scl         (o_scl),
        .o_sda         (o_sda),
        .o_last_sample (o_last_sample),
        .o_status      (back_status)
    );

    // The queue is never written while full.
    `IWG_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, q_push && q_full)
    // Every byte ends on a sample with SCL high (ACK or STOP).
    `IWG_ASSERT(a_last_scl_high, i_clk, i_rst_n, o_out_valid && o_last_sample |-> o_scl)
    // A waiting command is picked up by an idle sequencer at once.
    `IWG_ASSERT(a_pickup, i_clk, i_rst_n, q_valid && !back_status.busy |=> back_status.busy)

endmodule

`default_nettype wire

// File: sv/iwg_front.sv
// Front end: accepts byte beats, tracks frame opening and orders the data bits.
// Depends on iwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iwg_front
    import iwg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic                 i_cfg_wr_data,
    input  wire logic                 i_in_valid,
    input  wire logic [DATA_BITS-1:0] i_data_byte,
    input  wire logic                 i_last_byte,
    output logic                      o_in_stall,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_cmd                      o_q_cmd
);

    logic r_lsb_first;
    logic r_in_frame;
    logic [DATA_BITS-1:0] s_rev;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_first <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_lsb_first <= i_cfg_wr_data;
        end
    end

    // A beat is taken whenever the queue has room.
    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    // Frame tracking: a frame stays open until its last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (o_q_push) begin
            r_in_frame <= !i_last_byte;
        end
    end

    // Bit reversal for least-significant-first sending.
    always_comb begin
        for (int k = 0; k < DATA_BITS; k++) begin
            s_rev[k] = i_data_byte[DATA_BITS-1-k];
        end
    end

    always_comb begin
        o_q_cmd.data       = r_lsb_first ? s_rev : i_data_byte;
        o_q_cmd.open_frame = !r_in_frame;
        o_q_cmd.last_byte  = i_last_byte;
    end

endmodule

`default_nettype wire

// File: sv/iwg_queue.sv
// Short command queue between the front end and the back sequencer.
// Depends on iwg_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module iwg_queue
    import iwg_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/iwg_back.sv
// Back sequencer: walks one byte command through its optional prefix, data, ACK and optional STOP,
// emitting one (SCL, SDA) sample per cycle into an output register while the output is not stalled.
// Depends on iwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iwg_back
    import iwg_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_cmd   i_q_cmd,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output logic        o_scl,
    output logic        o_sda,
    output logic        o_last_sample,
    output t_back_status o_status
);

    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_ACK  = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    logic                 r_busy, n_busy;
    logic [1:0]           r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [1:0]           r_sub, n_sub;
    logic [DATA_BITS-1:0] r_sh, n_sh;
    logic                 r_stop, n_stop;
    logic                 r_prev_sda, n_prev_sda;
    logic                 r_out_valid;
    logic                 r_scl, r_sda, r_last;

    logic s_scl, s_sda, s_last;
    logic s_adv, s_step, s_take;

    // The output register moves when empty or when its beat is taken.
    assign s_adv  = !r_out_valid || !i_out_stall;
    assign s_step = r_busy && s_adv;
    assign s_take = i_q_valid && (!r_busy || (s_step && s_last));
    assign o_q_pop = s_take;

    // Sample for the current position of the sequence.
    always_comb begin
        s_scl  = 1'b0;
        s_sda  = 1'b0;
        s_last = 1'b0;
        unique case (r_phase)
            PH_PRE: begin
                // START high pair at the first step, then SCL pulses with SDA low.
                s_scl = (r_cnt == '0) ? 1'b1 : r_cnt[0];
                s_sda = (r_cnt == '0);
            end
            PH_DATA: begin
                s_scl = (r_sub == 2'd2);
                s_sda = (r_sub == 2'd0) ? r_prev_sda : r_sh[DATA_BITS-1];
            end
            PH_ACK: begin
                s_scl  = (r_sub == 2'd2);
                s_sda  = (r_sub == 2'd0) ? r_prev_sda : 1'b0;
                s_last = (r_sub == 2'd2) && !r_stop;
            end
            PH_STOP: begin
                s_scl  = r_sub[1];
                s_sda  = (r_sub == 2'd0) ? r_prev_sda : (r_sub == 2'd3);
                s_last = (r_sub == 2'd3);
            end
        endcase
    end

    // Next position of the sequence, and loading of a new command.
    always_comb begin
        n_busy     = r_busy;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_sub      = r_sub;
        n_sh       = r_sh;
        n_stop     = r_stop;
        n_prev_sda = r_prev_sda;
        if (s_step) begin
            n_prev_sda = s_sda;
            unique case (r_phase)
                PH_PRE: begin
                    if (r_cnt == CNT_W'(PRE_SAMPLES - 1)) begin
                        n_phase = PH_DATA;
                        n_cnt   = '0;
                        n_sub   = 2'd0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                PH_DATA: begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        n_sh  = {r_sh[DATA_BITS-2:0], 1'b0};
                        if (r_cnt == CNT_W'(DATA_BITS - 1)) begin
                            n_phase = PH_ACK;
                            n_cnt   = '0;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
                PH_ACK: begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        if (r_stop) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_busy = 1'b0;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
                PH_STOP: begin
                    if (r_sub == 2'd3) begin
                        n_sub  = 2'd0;
                        n_busy = 1'b0;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            endcase
        end
        if (s_take) begin
            n_busy  = 1'b1;
            n_phase = i_q_cmd.open_frame ? PH_PRE : PH_DATA;
            n_cnt   = '0;
            n_sub   = 2'd0;
            n_sh    = i_q_cmd.data;
            n_stop  = i_q_cmd.last_byte;
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_PRE;
            r_cnt       <= '0;
            r_sub       <= 2'd0;
            r_prev_sda  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_sub      <= n_sub;
            r_prev_sda <= n_prev_sda;
            if (s_adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // Command payload and output sample register.
    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_stop <= n_stop;
        if (s_adv) begin
            r_scl  <= s_scl;
            r_sda  <= s_sda;
            r_last <= s_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scl           = r_scl;
    assign o_sda           = r_sda;
    assign o_last_sample   = r_last;
    assign o_status.busy   = r_busy;
    assign o_status.phase  = r_phase;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for i2c_write_waveform_gen: byte beats in, (SCL, SDA) sample beats out.
// Depends on iwg_pkg and the generator RTL only; walks a directed table, then random frames,
// with every sample checked against a behavioural waveform predictor.
`timescale 1ns / 1ps

module tb;
    import iwg_pkg::*;

    // Samples per byte: data and ACK always, prefix when opening, STOP when closing.
    localparam int BYTE_SAMPLES = 27;
    localparam int STOP_SAMPLES = 4;
    localparam int LEN_MID      = BYTE_SAMPLES;
    localparam int LEN_OPEN     = PRE_SAMPLES + BYTE_SAMPLES;
    localparam int LEN_CLOSE    = BYTE_SAMPLES + STOP_SAMPLES;
    localparam int LEN_SINGLE   = PRE_SAMPLES + BYTE_SAMPLES + STOP_SAMPLES;
    localparam int LEN_ANY      = 0;

    // Values of the bit order register.
    localparam logic MSB_FIRST = 1'b0;
    localparam logic LSB_FIRST = 1'b1;

    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic scl;
        logic sda;
        logic end_of_byte;
    } wave_sample_t;

    typedef struct {
        bit         wr_order;
        logic       order;
        logic [7:0] data;
        logic       last;
        int         n_samples;
    } dir_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] data_byte   = 8'h00;
    logic       last_byte   = 1'b0;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       scl;
    logic       sda;
    logic       last_sample;

    // Predictor state and the store of expected samples.
    logic         model_lsb_first;
    logic         model_prev_sda;
    logic         model_in_frame;
    wave_sample_t wave_q[$];
    int           byte_len_q[$];
    int           byte_len_next = LEN_ANY;
    int           cur_len       = 0;
    int           errors        = 0;
    int           cycles        = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;

    // Directed beats: extremes, both bit orders, single-byte frames and order changes mid-frame.
    dir_row_t dir_rows [0:15] = '{
        '{1'b1, MSB_FIRST, 8'h00, 1'b1, LEN_SINGLE},
        '{1'b0, MSB_FIRST, 8'hFF, 1'b1, LEN_SINGLE},
        '{1'b0, MSB_FIRST, 8'hA5, 1'b0, LEN_OPEN},
        '{1'b0, MSB_FIRST, 8'h5A, 1'b0, LEN_MID},
        '{1'b0, MSB_FIRST, 8'h80, 1'b0, LEN_MID},
        '{1'b0, MSB_FIRST, 8'h01, 1'b1, LEN_CLOSE},
        '{1'b1, LSB_FIRST, 8'h01, 1'b0, LEN_OPEN},
        '{1'b0, LSB_FIRST, 8'h80, 1'b0, LEN_MID},
        '{1'b1, MSB_FIRST, 8'hC3, 1'b0, LEN_MID},
        '{1'b1, LSB_FIRST, 8'h96, 1'b1, LEN_CLOSE},
        '{1'b0, LSB_FIRST, 8'hFE, 1'b1, LEN_SINGLE},
        '{1'b0, LSB_FIRST, 8'h7F, 1'b0, LEN_OPEN},
        '{1'b0, LSB_FIRST, 8'h00, 1'b0, LEN_MID},
        '{1'b0, LSB_FIRST, 8'hFF, 1'b0, LEN_MID},
        '{1'b0, LSB_FIRST, 8'h55, 1'b1, LEN_CLOSE},
        '{1'b1, MSB_FIRST, 8'hAA, 1'b1, LEN_SINGLE}
    };

    logic       phase_order [0:RAND_PHASES-1] = '{LSB_FIRST, MSB_FIRST, LSB_FIRST, LSB_FIRST,
                                                  MSB_FIRST};
    idle_mode_e phase_idle  [0:RAND_PHASES-1] = '{IDLE_BOTH, IDLE_NONE, IDLE_SEND, IDLE_RECV,
                                                  IDLE_NONE};

    i2c_write_waveform_gen dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_data_byte   (data_byte),
        .i_last_byte   (last_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_scl         (scl),
        .o_sda         (sda),
        .o_last_sample (last_sample)
    );

    always #5 clk = ~clk;

    // Reset is held at the start and never again.
    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Append one expected sample and track the SDA level it leaves behind.
    function automatic void push_sample(input logic s_scl, input logic s_sda);
        wave_q.push_back('{s_scl, s_sda, 1'b0});
        model_prev_sda = s_sda;
    endfunction

    // Expected waveform of one byte beat: optional prefix, data bits, ACK, optional STOP.
    function automatic void predict_waveform(input logic [7:0] d, input logic l);
        int   pos;
        logic b;
        if (!model_in_frame) begin
            push_sample(1'b1, 1'b1);
            push_sample(1'b1, 1'b0);
            for (int i = 0; i < (PRE_SAMPLES - 2) / 2; i++) begin
                push_sample(1'b0, 1'b0);
                push_sample(1'b1, 1'b0);
            end
            model_in_frame = 1'b1;
        end
        for (int i = 0; i < DATA_BITS; i++) begin
            pos = (model_lsb_first == LSB_FIRST) ? i : DATA_BITS - 1 - i;
            b   = d[pos];
            push_sample(1'b0, model_prev_sda);
            push_sample(1'b0, b);
            push_sample(1'b1, b);
        end
        push_sample(1'b0, model_prev_sda);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        if (l) begin
            push_sample(1'b0, model_prev_sda);
            push_sample(1'b0, 1'b0);
            push_sample(1'b1, 1'b0);
            push_sample(1'b1, 1'b1);
            model_in_frame = 1'b0;
        end
        wave_q[wave_q.size() - 1].end_of_byte = 1'b1;
    endfunction

    // Check output beats first, then predict from input beats and register writes.
    always @(posedge clk) begin
        wave_sample_t want;
        int           want_len;
        if (!rst_n) begin
            model_lsb_first = MSB_FIRST;
            model_prev_sda  = 1'b0;
            model_in_frame  = 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                cur_len++;
                if (wave_q.size() == 0) begin
                    $display("%0t: sample beat with none expected: scl=%b sda=%b last=%b",
                             $time, scl, sda, last_sample);
                    errors++;
                end else begin
                    want = wave_q.pop_front();
                    if (scl !== want.scl) begin
                        $display("%0t: scl expected %b actual %b", $time, want.scl, scl);
                        errors++;
                    end
                    if (sda !== want.sda) begin
                        $display("%0t: sda expected %b actual %b", $time, want.sda, sda);
                        errors++;
                    end
                    if (last_sample !== want.end_of_byte) begin
                        $display("%0t: last_sample expected %b actual %b",
                                 $time, want.end_of_byte, last_sample);
                        errors++;
                    end
                end
                // Directed rows also carry the sample count of their byte.
                if (last_sample === 1'b1) begin
                    if (byte_len_q.size() != 0) begin
                        want_len = byte_len_q.pop_front();
                        if (want_len != LEN_ANY && want_len != cur_len) begin
                            $display("%0t: samples per byte expected %0d actual %0d",
                                     $time, want_len, cur_len);
                            errors++;
                        end
                    end
                    cur_len = 0;
                end
            end
            if (cfg_wr_en)
                model_lsb_first = cfg_wr_data;
            if (in_valid && !in_stall) begin
                predict_waveform(data_byte, last_byte);
                byte_len_q.push_back(byte_len_next);
            end
        end
    end

    // Receiver stalls at random on the falling edge.
    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic void set_idle_mode(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 55; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 55; end
            default:   begin send_idle_pct = 10; stall_pct = 10; end
        endcase
    endfunction

    // Offer one byte beat, with random gaps before it, and hold it until taken.
    task automatic send_byte(input logic [7:0] d, input logic l, input int n_samples);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= d;
        last_byte     <= l;
        byte_len_next  = n_samples;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Wait until every expected sample is out, then change the bit order.
    task automatic write_order(input logic order);
        in_valid <= 1'b0;
        while (wave_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stimulus: directed table, then random frames over several idling phases.
    initial begin
        int   sent;
        int   frame_len;
        logic l;
        wait (rst_n === 1'b1);
        @(negedge clk);
        set_idle_mode(IDLE_NONE);

        for (int r = 0; r < $size(dir_rows); r++) begin
            if (dir_rows[r].wr_order)
                write_order(dir_rows[r].order);
            send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].n_samples);
        end

        // Mostly well-formed frames of one to eight bytes; some beats get a random last flag.
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_order(phase_order[p]);
            set_idle_mode(phase_idle[p]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                frame_len = $urandom_range(1, 8);
                for (int k = 0; k < frame_len; k++) begin
                    if ($urandom_range(0, 99) < 15)
                        l = $urandom_range(0, 1);
                    else
                        l = (k == frame_len - 1);
                    send_byte($urandom_range(0, 255), l, LEN_ANY);
                end
                sent += frame_len;
            end
        end

        // Drain, allow for the pipeline, then report.
        in_valid <= 1'b0;
        while (wave_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && wave_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
